// File: hdl/mos_pkg.sv
// Shared types, constants, arithmetic helpers and microprogram for the Milne ODE solver.
`timescale 1ns / 1ps

package mos_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DEF_MAX_START_STEPS = 4096;
   localparam int DEF_MAX_CORRECTOR_ITERS = 16;
   localparam int DIV_W = 35;
   localparam int DVS_W = 31;
   localparam int ACC_W = 36;
   localparam int PC_W = 7;

   localparam logic [30:0] STEP_RESET = 31'd13107;
   localparam logic [15:0] TOL_RESET = 16'd7;

   localparam logic REG_STEP = 1'b0;
   localparam logic REG_TOL = 1'b1;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_STEPS = 2'd1;
   localparam logic [1:0] STS_NOCONV = 2'd2;

   localparam logic [PC_W-1:0] PC_LOOP = 7'd11;
   localparam logic [PC_W-1:0] PC_AFTER = 7'd14;
   localparam logic [PC_W-1:0] PC_CLOOP = 7'd49;
   localparam logic [PC_W-1:0] PC_RK4 = 7'd67;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DIV, ST_DONE} state_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_MUL, OP_MULWB, OP_ADD, OP_HADD, OP_NEG2, OP_ACC_LD, OP_ACC_ADD,
      OP_ACCSAT, OP_DIV, OP_DIVWB, OP_NLOAD, OP_NDEC, OP_ILOAD, OP_CHK, OP_FIN
   } op_type;

   typedef enum logic [4:0] {
      R_ZERO, R_X, R_Y, R_H, R_XB, R_XE, R_XM, R_YA, R_K, R_T, R_Y0, R_Y1, R_Y2,
      R_Y3, R_FN1, R_FN, R_EST, R_H3, R_H43
   } reg_id_type;

   typedef enum logic [2:0] {C_P1, C_P2, C_P4, C_M1, C_M4} coef_type;

   typedef enum logic [1:0] {DM_STEPS, DM_H3, DM_H43, DM_SIX} div_mode_type;

   typedef enum logic [2:0] {BR_NONE, BR_JUMP, BR_NZ, BR_CORR, BR_CALL, BR_RET, BR_END} br_type;

   typedef struct packed {
      op_type       op;
      reg_id_type   a;
      reg_id_type   b;
      reg_id_type   dst;
      coef_type     coef;
      div_mode_type dm;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic n_zero;
      logic iter_zero;
      logic conv;
   } stat_type;

   typedef struct packed {
      cmd_type         cmd;
      br_type          br;
      logic [PC_W-1:0] tgt;
   } uop_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sh000000007FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh0000000080000000) return -32'sh80000000;
      return v[31:0];
   endfunction

   function automatic uop_type u_op(input op_type op, input reg_id_type a, input reg_id_type b,
                                    input reg_id_type dst);
      uop_type u;
      u.cmd.op = op;
      u.cmd.a = a;
      u.cmd.b = b;
      u.cmd.dst = dst;
      u.cmd.coef = C_P1;
      u.cmd.dm = DM_STEPS;
      u.br = BR_NONE;
      u.tgt = '0;
      return u;
   endfunction

   function automatic uop_type u_acc(input op_type op, input reg_id_type a, input coef_type c);
      uop_type u;
      u = u_op(op, a, R_ZERO, R_ZERO);
      u.cmd.coef = c;
      return u;
   endfunction

   function automatic uop_type u_div(input div_mode_type dm);
      uop_type u;
      u = u_op(OP_DIV, R_ZERO, R_ZERO, R_ZERO);
      u.cmd.dm = dm;
      return u;
   endfunction

   function automatic uop_type u_br(input uop_type base, input br_type br,
                                    input logic [PC_W-1:0] tgt);
      uop_type u;
      u = base;
      u.br = br;
      u.tgt = tgt;
      return u;
   endfunction

   // Five micro-operations computing T = -2*x*y*y.
   function automatic uop_type slope_u(input logic [2:0] k, input reg_id_type xa,
                                       input reg_id_type ya);
      uop_type u;
      case (k)
         3'd0: u = u_op(OP_MUL, xa, ya, R_ZERO);
         3'd1: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_T);
         3'd2: u = u_op(OP_MUL, R_T, ya, R_ZERO);
         3'd3: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_T);
         default: u = u_op(OP_NEG2, R_T, R_ZERO, R_T);
      endcase
      return u;
   endfunction

   function automatic uop_type ucode(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc) inside
         7'd0: u = u_acc(OP_ACC_LD, R_XE, C_P1);
         7'd1: u = u_acc(OP_ACC_ADD, R_H, C_M4);
         7'd2: u = u_op(OP_ACCSAT, R_ZERO, R_ZERO, R_XB);
         7'd3: u = u_acc(OP_ACC_LD, R_XB, C_P1);
         7'd4: u = u_acc(OP_ACC_ADD, R_X, C_M1);
         7'd5: u = u_div(DM_STEPS);
         7'd6: u = u_op(OP_NLOAD, R_ZERO, R_ZERO, R_ZERO);
         7'd7: u = u_div(DM_H3);
         7'd8: u = u_op(OP_DIVWB, R_ZERO, R_ZERO, R_H3);
         7'd9: u = u_div(DM_H43);
         7'd10: u = u_op(OP_DIVWB, R_ZERO, R_ZERO, R_H43);
         7'd11: u = u_br(u_op(OP_NOP, R_ZERO, R_ZERO, R_ZERO), BR_NZ, PC_AFTER);
         7'd12: u = u_br(u_op(OP_NOP, R_ZERO, R_ZERO, R_ZERO), BR_CALL, PC_RK4);
         7'd13: u = u_br(u_op(OP_NDEC, R_ZERO, R_ZERO, R_ZERO), BR_JUMP, PC_LOOP);
         7'd14: u = u_op(OP_ADD, R_Y, R_ZERO, R_Y3);
         7'd15: u = u_op(OP_ADD, R_XB, R_ZERO, R_X);
         7'd16: u = u_br(u_op(OP_NOP, R_ZERO, R_ZERO, R_ZERO), BR_CALL, PC_RK4);
         7'd17: u = u_br(u_op(OP_ADD, R_Y, R_ZERO, R_Y2), BR_CALL, PC_RK4);
         7'd18: u = u_br(u_op(OP_ADD, R_Y, R_ZERO, R_Y1), BR_CALL, PC_RK4);
         7'd19: u = u_op(OP_ADD, R_Y, R_ZERO, R_Y0);
         7'd20: u = u_op(OP_ADD, R_XB, R_ZERO, R_X);
         7'd21: u = u_op(OP_ADD, R_X, R_H, R_X);
         [7'd22:7'd26]: u = slope_u(3'(pc - 7'd22), R_X, R_Y2);
         7'd27: u = u_acc(OP_ACC_LD, R_T, C_P2);
         7'd28: u = u_op(OP_ADD, R_X, R_H, R_X);
         [7'd29:7'd33]: u = slope_u(3'(pc - 7'd29), R_X, R_Y1);
         7'd34: u = u_op(OP_ADD, R_T, R_ZERO, R_FN1);
         7'd35: u = u_acc(OP_ACC_ADD, R_T, C_M1);
         7'd36: u = u_op(OP_ADD, R_X, R_H, R_X);
         [7'd37:7'd41]: u = slope_u(3'(pc - 7'd37), R_X, R_Y0);
         7'd42: u = u_op(OP_ADD, R_T, R_ZERO, R_FN);
         7'd43: u = u_acc(OP_ACC_ADD, R_T, C_P2);
         7'd44: u = u_op(OP_ACCSAT, R_ZERO, R_ZERO, R_K);
         7'd45: u = u_op(OP_MUL, R_H43, R_K, R_ZERO);
         7'd46: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_T);
         7'd47: u = u_op(OP_ADD, R_Y3, R_T, R_EST);
         7'd48: u = u_op(OP_ILOAD, R_ZERO, R_ZERO, R_ZERO);
         [7'd49:7'd53]: u = slope_u(3'(pc - 7'd49), R_XE, R_EST);
         7'd54: u = u_acc(OP_ACC_LD, R_FN1, C_P1);
         7'd55: u = u_acc(OP_ACC_ADD, R_FN, C_P4);
         7'd56: u = u_acc(OP_ACC_ADD, R_T, C_P1);
         7'd57: u = u_op(OP_ACCSAT, R_ZERO, R_ZERO, R_K);
         7'd58: u = u_op(OP_MUL, R_H3, R_K, R_ZERO);
         7'd59: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_T);
         7'd60: u = u_op(OP_ADD, R_Y1, R_T, R_T);
         7'd61: u = u_acc(OP_ACC_LD, R_T, C_P1);
         7'd62: u = u_acc(OP_ACC_ADD, R_EST, C_M1);
         7'd63: u = u_op(OP_ADD, R_T, R_ZERO, R_EST);
         7'd64: u = u_op(OP_CHK, R_ZERO, R_ZERO, R_ZERO);
         7'd65: u = u_br(u_op(OP_NOP, R_ZERO, R_ZERO, R_ZERO), BR_CORR, PC_CLOOP);
         7'd66: u = u_br(u_op(OP_FIN, R_ZERO, R_ZERO, R_ZERO), BR_END, '0);
         7'd67: u = u_op(OP_HADD, R_X, R_H, R_XM);
         [7'd68:7'd72]: u = slope_u(3'(pc - 7'd68), R_X, R_Y);
         7'd73: u = u_op(OP_MUL, R_H, R_T, R_ZERO);
         7'd74: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_K);
         7'd75: u = u_acc(OP_ACC_LD, R_K, C_P1);
         7'd76: u = u_op(OP_HADD, R_Y, R_K, R_YA);
         [7'd77:7'd81]: u = slope_u(3'(pc - 7'd77), R_XM, R_YA);
         7'd82: u = u_op(OP_MUL, R_H, R_T, R_ZERO);
         7'd83: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_K);
         7'd84: u = u_acc(OP_ACC_ADD, R_K, C_P2);
         7'd85: u = u_op(OP_HADD, R_Y, R_K, R_YA);
         [7'd86:7'd90]: u = slope_u(3'(pc - 7'd86), R_XM, R_YA);
         7'd91: u = u_op(OP_MUL, R_H, R_T, R_ZERO);
         7'd92: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_K);
         7'd93: u = u_acc(OP_ACC_ADD, R_K, C_P2);
         7'd94: u = u_op(OP_ADD, R_Y, R_K, R_YA);
         7'd95: u = u_op(OP_ADD, R_X, R_H, R_XM);
         [7'd96:7'd100]: u = slope_u(3'(pc - 7'd96), R_XM, R_YA);
         7'd101: u = u_op(OP_MUL, R_H, R_T, R_ZERO);
         7'd102: u = u_op(OP_MULWB, R_ZERO, R_ZERO, R_K);
         7'd103: u = u_acc(OP_ACC_ADD, R_K, C_P1);
         7'd104: u = u_div(DM_SIX);
         7'd105: u = u_op(OP_DIVWB, R_ZERO, R_ZERO, R_T);
         7'd106: u = u_op(OP_ADD, R_Y, R_T, R_Y);
         7'd107: u = u_br(u_op(OP_ADD, R_X, R_H, R_X), BR_RET, '0);
         default: u = u_op(OP_NOP, R_ZERO, R_ZERO, R_ZERO);
      endcase
      return u;
   endfunction

endpackage

// File: hdl/mos_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mos_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mos_pkg::DIV_W-1:0]    dividend,
   input  logic [mos_pkg::DVS_W-1:0]    divisor,
   output logic                         busy,
   output logic [mos_pkg::DIV_W-1:0]    quotient
);

   localparam int CW = $clog2(mos_pkg::DIV_W + 1);

   logic [mos_pkg::DVS_W:0]   rem_ff, rem_in;
   logic [mos_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [mos_pkg::DVS_W-1:0] dvs_ff;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [mos_pkg::DVS_W:0]   trial;

   always_comb begin
      trial = {rem_ff[mos_pkg::DVS_W-1:0], quo_ff[mos_pkg::DIV_W-1]};
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CW'(mos_pkg::DIV_W);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[mos_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[mos_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

// File: hdl/mos_datapath.sv
// Datapath: operand registers, shared multiplier, accumulator, divider and loop counters.
`timescale 1ns / 1ps

module mos_datapath #(
   parameter int MAX_START_STEPS = mos_pkg::DEF_MAX_START_STEPS,
   parameter int MAX_CORRECTOR_ITERS = mos_pkg::DEF_MAX_CORRECTOR_ITERS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mos_pkg::cmd_type    cmd,
   input  logic signed [31:0]  x_start,
   input  logic signed [31:0]  y_start,
   input  logic signed [31:0]  x_end,
   input  logic [30:0]         step,
   input  logic [15:0]         tol,
   output mos_pkg::stat_type   stat,
   output logic signed [31:0]  y_result,
   output logic [1:0]          status
);

   localparam int NW = $clog2(MAX_START_STEPS + 1);
   localparam int IW = $clog2(MAX_CORRECTOR_ITERS + 1);
   localparam int AW = mos_pkg::ACC_W;
   localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
   localparam logic [31:0] THIRD_2_32 = 32'd1431655765;

   logic signed [31:0] x_ff, y_ff, h_ff, xb_ff, xe_ff, xm_ff, ya_ff, k_ff, t_ff;
   logic signed [31:0] y0_ff, y1_ff, y2_ff, y3_ff, fn1_ff, fn_ff, est_ff, h3_ff, h43_ff;
   logic signed [63:0] p_ff;
   logic signed [AW-1:0] acc_ff;
   logic               neg_ff;
   logic [NW-1:0]      n_ff;
   logic [IW-1:0]      iter_ff;
   logic               conv_ff;
   logic [1:0]         status_ff;

   logic signed [31:0] opa, opb, wb_val, mulr, divv;
   logic signed [63:0] opa64, opb64;
   logic signed [AW-1:0] a_ext, term, acc_abs;
   logic               wb_en;
   logic               div_start, div_busy;
   logic [mos_pkg::DIV_W-1:0] div_dividend, quo;
   logic [mos_pkg::DVS_W-1:0] div_divisor;
   logic signed [63:0] q64;

   // Division by three: fold bit 32 into the low word, multiply by the reciprocal.
   logic               div3_start;
   logic [32:0]        t3;
   logic [31:0]        c3_in, c3_ff, q3_ff;
   logic               hi3_ff, s3_ff;
   logic [63:0]        p3_ff;

   function automatic logic signed [31:0] pick(input mos_pkg::reg_id_type r);
      case (r)
         mos_pkg::R_X:   return x_ff;
         mos_pkg::R_Y:   return y_ff;
         mos_pkg::R_H:   return h_ff;
         mos_pkg::R_XB:  return xb_ff;
         mos_pkg::R_XE:  return xe_ff;
         mos_pkg::R_XM:  return xm_ff;
         mos_pkg::R_YA:  return ya_ff;
         mos_pkg::R_K:   return k_ff;
         mos_pkg::R_T:   return t_ff;
         mos_pkg::R_Y0:  return y0_ff;
         mos_pkg::R_Y1:  return y1_ff;
         mos_pkg::R_Y2:  return y2_ff;
         mos_pkg::R_Y3:  return y3_ff;
         mos_pkg::R_FN1: return fn1_ff;
         mos_pkg::R_FN:  return fn_ff;
         mos_pkg::R_EST: return est_ff;
         mos_pkg::R_H3:  return h3_ff;
         mos_pkg::R_H43: return h43_ff;
         default:        return 32'sd0;
      endcase
   endfunction

   always_comb begin
      opa = pick(cmd.a);
      opb = pick(cmd.b);
      opa64 = {{32{opa[31]}}, opa};
      opb64 = {{32{opb[31]}}, opb};
      a_ext = {{(AW-32){opa[31]}}, opa};
      case (cmd.coef)
         mos_pkg::C_P2: term = a_ext <<< 1;
         mos_pkg::C_P4: term = a_ext <<< 2;
         mos_pkg::C_M1: term = -a_ext;
         mos_pkg::C_M4: term = -(a_ext <<< 2);
         default:       term = a_ext;
      endcase
      acc_abs = acc_ff[AW-1] ? -acc_ff : acc_ff;
      mulr = mos_pkg::sat32((p_ff + (64'sd1 <<< (mos_pkg::FRAC_BITS - 1)))
                            >>> mos_pkg::FRAC_BITS);
      q64 = $signed({32'd0, q3_ff});
      divv = mos_pkg::sat32(neg_ff ? -q64 : q64);
   end

   always_comb begin
      div_dividend = '0;
      div_divisor = h_ff[30:0];
      if (!acc_ff[AW-1] && acc_ff != '0) begin
         div_dividend = acc_ff[mos_pkg::DIV_W-1:0];
      end
      case (cmd.dm)
         mos_pkg::DM_H3:  t3 = {2'b0, h_ff[30:0]};
         mos_pkg::DM_H43: t3 = {h_ff[30:0], 2'b0};
         default:         t3 = acc_abs[33:1];
      endcase
      c3_in = t3[31:0] + {31'd0, t3[32]};
   end

   assign div_start = (cmd.op == mos_pkg::OP_DIV) && (cmd.dm == mos_pkg::DM_STEPS);
   assign div3_start = (cmd.op == mos_pkg::OP_DIV) && (cmd.dm != mos_pkg::DM_STEPS);

   mos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quo)
   );

   always_comb begin
      wb_en = 1'b1;
      case (cmd.op)
         mos_pkg::OP_MULWB:  wb_val = mulr;
         mos_pkg::OP_ADD:    wb_val = mos_pkg::sat32(opa64 + opb64);
         mos_pkg::OP_HADD:   wb_val = mos_pkg::sat32(opa64 + (opb64 >>> 1));
         mos_pkg::OP_NEG2:   wb_val = mos_pkg::sat32(-(opa64 <<< 1));
         mos_pkg::OP_ACCSAT: wb_val = mos_pkg::sat32({{(64-AW){acc_ff[AW-1]}}, acc_ff});
         mos_pkg::OP_DIVWB:  wb_val = divv;
         default: begin
            wb_val = 32'sd0;
            wb_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= x_start;
         y_ff <= y_start;
         xe_ff <= x_end;
         h_ff <= {1'b0, (step == '0) ? 31'd1 : step};
      end else if (wb_en) begin
         case (cmd.dst)
            mos_pkg::R_X:   x_ff <= wb_val;
            mos_pkg::R_Y:   y_ff <= wb_val;
            mos_pkg::R_XB:  xb_ff <= wb_val;
            mos_pkg::R_XM:  xm_ff <= wb_val;
            mos_pkg::R_YA:  ya_ff <= wb_val;
            mos_pkg::R_K:   k_ff <= wb_val;
            mos_pkg::R_T:   t_ff <= wb_val;
            mos_pkg::R_Y0:  y0_ff <= wb_val;
            mos_pkg::R_Y1:  y1_ff <= wb_val;
            mos_pkg::R_Y2:  y2_ff <= wb_val;
            mos_pkg::R_Y3:  y3_ff <= wb_val;
            mos_pkg::R_FN1: fn1_ff <= wb_val;
            mos_pkg::R_FN:  fn_ff <= wb_val;
            mos_pkg::R_EST: est_ff <= wb_val;
            mos_pkg::R_H3:  h3_ff <= wb_val;
            mos_pkg::R_H43: h43_ff <= wb_val;
            default: ;
         endcase
      end
      if (cmd.op == mos_pkg::OP_MUL) begin
         p_ff <= opa * opb;
      end
      if (cmd.op == mos_pkg::OP_ACC_LD) begin
         acc_ff <= term;
      end else if (cmd.op == mos_pkg::OP_ACC_ADD) begin
         acc_ff <= acc_ff + term;
      end
      if (div3_start) begin
         neg_ff <= (cmd.dm == mos_pkg::DM_SIX) && acc_ff[AW-1];
         c3_ff <= c3_in;
         hi3_ff <= t3[32];
      end
      p3_ff <= c3_ff * RECIP3;
      q3_ff <= {1'b0, p3_ff[63:33]} + (hi3_ff ? THIRD_2_32 : 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff <= 1'b0;
      end else begin
         s3_ff <= div3_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         iter_ff <= '0;
         conv_ff <= 1'b0;
         status_ff <= mos_pkg::STS_OK;
      end else if (load) begin
         status_ff <= mos_pkg::STS_OK;
         conv_ff <= 1'b0;
      end else begin
         case (cmd.op)
            mos_pkg::OP_NLOAD: begin
               if (quo > mos_pkg::DIV_W'(MAX_START_STEPS)) begin
                  n_ff <= NW'(MAX_START_STEPS);
                  status_ff <= mos_pkg::STS_STEPS;
               end else begin
                  n_ff <= quo[NW-1:0];
               end
            end
            mos_pkg::OP_NDEC: n_ff <= n_ff - 1'b1;
            mos_pkg::OP_ILOAD: begin
               iter_ff <= IW'(MAX_CORRECTOR_ITERS);
               conv_ff <= 1'b0;
            end
            mos_pkg::OP_CHK: begin
               iter_ff <= iter_ff - 1'b1;
               conv_ff <= (acc_abs <= $signed({{(AW-16){1'b0}}, tol}));
            end
            mos_pkg::OP_FIN: begin
               if (!conv_ff && status_ff == mos_pkg::STS_OK) begin
                  status_ff <= mos_pkg::STS_NOCONV;
               end
            end
            default: ;
         endcase
      end
   end

   assign stat.div_busy = div_busy || s3_ff;
   assign stat.n_zero = (n_ff == '0);
   assign stat.iter_zero = (iter_ff == '0);
   assign stat.conv = conv_ff;
   assign y_result = est_ff;
   assign status = status_ff;

endmodule

// File: hdl/mos_ctrl.sv
// Controller: state machine and microprogram sequencer issuing datapath commands.
`timescale 1ns / 1ps

module mos_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mos_pkg::stat_type   stat,
   output logic                busy,
   output logic                load,
   output logic                done,
   output mos_pkg::cmd_type    cmd
);

   mos_pkg::state_type state_ff, state_in;
   logic [mos_pkg::PC_W-1:0] pc_ff, pc_in, ret_ff, ret_in;
   mos_pkg::uop_type uop;
   mos_pkg::uop_type nop_u;
   logic [mos_pkg::PC_W-1:0] pc_next;

   assign uop = mos_pkg::ucode(pc_ff);
   assign nop_u = mos_pkg::u_op(mos_pkg::OP_NOP, mos_pkg::R_ZERO, mos_pkg::R_ZERO,
                                mos_pkg::R_ZERO);
   assign pc_next = mos_pkg::PC_W'(pc_ff + 1'b1);

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      ret_in = ret_ff;
      unique case (state_ff)
         mos_pkg::ST_IDLE: begin
            pc_in = '0;
            if (start) state_in = mos_pkg::ST_RUN;
         end
         mos_pkg::ST_RUN: begin
            pc_in = pc_next;
            if (uop.cmd.op == mos_pkg::OP_DIV) state_in = mos_pkg::ST_DIV;
            case (uop.br)
               mos_pkg::BR_JUMP: pc_in = uop.tgt;
               mos_pkg::BR_NZ: if (stat.n_zero) pc_in = uop.tgt;
               mos_pkg::BR_CORR: if (!(stat.conv || stat.iter_zero)) pc_in = uop.tgt;
               mos_pkg::BR_CALL: begin
                  pc_in = uop.tgt;
                  ret_in = pc_next;
               end
               mos_pkg::BR_RET: pc_in = ret_ff;
               mos_pkg::BR_END: state_in = mos_pkg::ST_DONE;
               default: ;
            endcase
         end
         mos_pkg::ST_DIV: begin
            if (!stat.div_busy) state_in = mos_pkg::ST_RUN;
         end
         mos_pkg::ST_DONE: state_in = mos_pkg::ST_IDLE;
         default: state_in = mos_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != mos_pkg::ST_IDLE);
      load = (state_ff == mos_pkg::ST_IDLE) && start;
      done = (state_ff == mos_pkg::ST_DONE);
      cmd = nop_u.cmd;
      unique case (state_ff)
         mos_pkg::ST_RUN: cmd = uop.cmd;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mos_pkg::ST_IDLE;
         pc_ff <= '0;
         ret_ff <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         ret_ff <= ret_in;
      end
   end

endmodule

// File: hdl/milne_ode_solver_unit.sv
// Top level of the Milne predictor-corrector ODE solver with register port.
`timescale 1ns / 1ps
//
// Solves y' = -2xy^2 in signed Q16.16 from (req_x_start, req_y_start) to req_x_end.
// A request word is taken at a clock edge with start high and busy low; busy then
// stays high until the result word has been shown. The result (rsp_y_result,
// rsp_status) is valid for exactly one cycle with rsp_valid high; the receiver
// cannot stall, so it must capture the word in that cycle.
// The register port holds step_size at byte address 0 and tolerance at 4; write
// them only while busy is low. Reset clears the sequencer and restores both
// registers to their defaults; no request is in progress after reset.
// The run takes n start steps (at most MAX_START_STEPS) and m corrector
// iterations (1 to MAX_CORRECTOR_ITERS). Each RK4 step runs as microcode through
// the shared multiplier, the division by six included; the start step count is
// found by one pass of the serial divider. One request is in flight at a time,
// so the next word is taken only after the previous result word has been shown.
//
module milne_ode_solver_unit #(
   parameter int MAX_START_STEPS = mos_pkg::DEF_MAX_START_STEPS,
   parameter int MAX_CORRECTOR_ITERS = mos_pkg::DEF_MAX_CORRECTOR_ITERS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_x_start,
   input  logic signed [31:0] req_y_start,
   input  logic signed [31:0] req_x_end,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_y_result,
   output logic [1:0]         rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [30:0] step_ff;
   logic [15:0] tol_ff;
   logic load;
   mos_pkg::cmd_type cmd;
   mos_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mos_pkg::STEP_RESET;
         tol_ff <= mos_pkg::TOL_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            mos_pkg::REG_STEP: step_ff <= pwdata[30:0];
            mos_pkg::REG_TOL:  tol_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         mos_pkg::REG_STEP: prdata = {1'b0, step_ff};
         mos_pkg::REG_TOL:  prdata = {16'b0, tol_ff};
         default:           prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   mos_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .load  (load),
      .done  (rsp_valid),
      .cmd   (cmd)
   );

   mos_datapath #(
      .MAX_START_STEPS     (MAX_START_STEPS),
      .MAX_CORRECTOR_ITERS (MAX_CORRECTOR_ITERS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .cmd      (cmd),
      .x_start  (req_x_start),
      .y_start  (req_y_start),
      .x_end    (req_x_end),
      .step     (step_ff),
      .tol      (tol_ff),
      .stat     (stat),
      .y_result (rsp_y_result),
      .status   (rsp_status)
   );

endmodule

// File: hdl/mos_checker.sv
// Port-level checker for the ODE solver, bound to the top level.
`timescale 1ns / 1ps

module mos_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [1:0]         rsp_status
);

   // A result word lasts one cycle and the block is free right after it.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result word longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted request did not make the block busy");

   a_word_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && rsp_status != 2'd3)
      else $error("result word outside a request or with bad status");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind milne_ode_solver_unit mos_checker u_mos_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the Milne ODE solver: a Q16.16 predictor scores every result word.
`timescale 1ns / 1ps

module testbench;

   localparam logic [2:0] ADDR_STEP = 3'd0;
   localparam logic [2:0] ADDR_TOL = 3'd4;
   localparam int WATCHDOG_LIMIT = 1500000;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   class milne_scoreboard;
      typedef struct {
         logic signed [31:0] y;
         logic [1:0]         status;
      } answer_type;

      answer_type answers[$];
      int         errors = 0;
      logic [30:0] step = mos_pkg::STEP_RESET;
      logic [15:0] tol = mos_pkg::TOL_RESET;

      function int clamp(longint v);
         if (v > Q_MAX) return int'(Q_MAX);
         if (v < Q_MIN) return int'(Q_MIN);
         return int'(v);
      endfunction

      function int fx_mul(int a, int b);
         longint p;
         p = longint'(a) * longint'(b) + 64'sd32768;
         return clamp(p >>> mos_pkg::FRAC_BITS);
      endfunction

      function int fx_add(int a, int b);
         return clamp(longint'(a) + longint'(b));
      endfunction

      function int deriv(int x, int y);
         int t;
         t = fx_mul(fx_mul(x, y), y);
         return clamp(-2 * longint'(t));
      endfunction

      function int rk4_advance(int x, int y, int h);
         int xm, k1, k2, k3, k4;
         longint sum;
         xm = fx_add(x, h >>> 1);
         k1 = fx_mul(h, deriv(x, y));
         k2 = fx_mul(h, deriv(xm, fx_add(y, k1 >>> 1)));
         k3 = fx_mul(h, deriv(xm, fx_add(y, k2 >>> 1)));
         k4 = fx_mul(h, deriv(fx_add(x, h), fx_add(y, k3)));
         sum = longint'(k1) + 2 * longint'(k2) + 2 * longint'(k3) + longint'(k4);
         return fx_add(y, clamp(sum / 6));
      endfunction

      function void note_request(int xs, int ys, int xe);
         int h, xb, x, y, y3, y2, y1, y0, yp, fn1, fn, h3, h43, est, a, b, c, s, nxt;
         longint d, n, diff;
         logic [1:0] st;
         bit converged;
         answer_type ans;
         h = (step == 0) ? 1 : int'(step);
         st = mos_pkg::STS_OK;
         converged = 0;
         xb = clamp(longint'(xe) - 4 * longint'(h));
         d = longint'(xb) - longint'(xs);
         n = (d > 0) ? d / longint'(h) : 0;
         if (n > mos_pkg::DEF_MAX_START_STEPS) begin
            n = mos_pkg::DEF_MAX_START_STEPS;
            st = mos_pkg::STS_STEPS;
         end
         x = xs;
         y = ys;
         for (longint i = 0; i < n; i++) begin
            y = rk4_advance(x, y, h);
            x = fx_add(x, h);
         end
         y3 = y;
         y2 = rk4_advance(xb, y3, h);
         y1 = rk4_advance(clamp(longint'(xb) + h), y2, h);
         y0 = rk4_advance(clamp(longint'(xb) + 2 * longint'(h)), y1, h);
         h3 = clamp(longint'(h) / 3);
         h43 = clamp(4 * longint'(h) / 3);
         a = deriv(clamp(longint'(xb) + h), y2);
         b = deriv(clamp(longint'(xb) + 2 * longint'(h)), y1);
         c = deriv(clamp(longint'(xb) + 3 * longint'(h)), y0);
         s = clamp(2 * longint'(a) - longint'(b) + 2 * longint'(c));
         yp = fx_add(y3, fx_mul(h43, s));
         fn1 = b;
         fn = c;
         est = yp;
         for (int i = 0; i < mos_pkg::DEF_MAX_CORRECTOR_ITERS && !converged; i++) begin
            s = clamp(longint'(fn1) + 4 * longint'(fn) + longint'(deriv(xe, est)));
            nxt = fx_add(y1, fx_mul(h3, s));
            diff = longint'(nxt) - longint'(est);
            if (diff < 0) diff = -diff;
            est = nxt;
            if (diff <= longint'(tol)) converged = 1;
         end
         if (!converged && st == mos_pkg::STS_OK) st = mos_pkg::STS_NOCONV;
         ans.y = est;
         ans.status = st;
         answers.push_back(ans);
      endfunction

      function void check_result(logic signed [31:0] y, logic [1:0] status);
         answer_type ans;
         if (answers.size() == 0) begin
            $display("%0t: unexpected result word y=%h status=%0d", $time, y, status);
            errors++;
            return;
         end
         ans = answers.pop_front();
         if (y !== ans.y) begin
            $display("%0t: y_result expected %h actual %h", $time, ans.y, y);
            errors++;
         end
         if (status !== ans.status) begin
            $display("%0t: status expected %0d actual %0d", $time, ans.status, status);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_x_start;
   logic signed [31:0] req_y_start;
   logic signed [31:0] req_x_end;
   logic               rsp_valid;
   logic signed [31:0] rsp_y_result;
   logic [1:0]         rsp_status;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   milne_scoreboard sb;
   int              quiet_cycles;

   milne_ode_solver_unit uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_y_result, rsp_status);
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int clip(longint v);
      if (v > Q_MAX) return int'(Q_MAX);
      if (v < Q_MIN) return int'(Q_MIN);
      return int'(v);
   endfunction

   task automatic send_request(int xs, int ys, int xe);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      repeat (gap) begin
         start = 1'b0;
         @(negedge clock);
      end
      start = 1'b1;
      req_x_start = xs;
      req_y_start = ys;
      req_x_end = xe;
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note_request(xs, ys, xe);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_reg(logic [2:0] addr, logic [31:0] data);
      while (sb.answers.size() != 0 || busy) @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      while (!pready) @(negedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (addr == ADDR_STEP) sb.step = data[30:0];
      else sb.tol = data[15:0];
   endtask

   task automatic configure(logic [30:0] h, logic [15:0] t);
      write_reg(ADDR_STEP, {1'b0, h});
      write_reg(ADDR_TOL, {16'd0, t});
   endtask

   task automatic random_requests(int count);
      int h, xs, ys, xe;
      for (int i = 0; i < count; i++) begin
         h = (sb.step == 0) ? 1 : int'(sb.step);
         if ($urandom_range(0, 3) != 0) begin
            xs = int'($urandom_range(0, 32'h60000)) - 32'sh30000;
            ys = int'($urandom_range(0, 32'h40000)) - 32'sh20000;
            xe = clip(longint'(xs) + longint'($urandom_range(4, 14)) * h
                      + longint'($urandom_range(0, h - 1)));
         end else if (h >= (1 << 20)) begin
            xs = $urandom;
            ys = $urandom;
            xe = $urandom;
         end else begin
            xs = $urandom;
            ys = $urandom;
            xe = clip(longint'(xs) + longint'($urandom_range(0, 24 * h)) - 8 * longint'(h));
         end
         send_request(xs, ys, xe);
      end
   endtask

   initial begin
      sb = new();
      quiet_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_x_start = '0;
      req_y_start = '0;
      req_x_end = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_request(32'sh0, 32'sh10000, 32'sh10000);
      send_request(32'sh0, 32'sh10000, 32'sh0000CCCC);
      send_request(32'sh10000, 32'sh8000, -32'sh10000);
      send_request(32'sh0, -32'sh80000000, 32'sh50000);
      send_request(32'sh0, 32'sh7FFFFFFF, 32'sh50000);
      send_request(32'sh0, 32'sh0, 32'sh40000);
      send_request(-32'sh80000000, 32'sh10000, -32'sh80000000);
      send_request(32'sh7FFF0000, 32'sh20000, 32'sh7FFFFFFF);
      send_request(-32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_request(32'sh0, 32'sh7FFF0000, 32'sh3333 * 9);
      send_request(32'sh0, 32'sh30000, 32'sh3333 * 4);

      configure(31'd4096, 16'd0);
      random_requests(60);
      configure(31'd1, 16'hFFFF);
      random_requests(40);
      configure(31'h7FFFFFFF, 16'($urandom));
      random_requests(30);
      configure(31'($urandom_range(1 << 21, 32'h7FFFFFFF)), 16'($urandom));
      random_requests(70);
      configure(31'd65536, 16'd7);
      random_requests(60);
      configure(31'($urandom_range(100, 200000)), 16'($urandom_range(0, 64)));
      random_requests(40);

      while (sb.answers.size() != 0) @(negedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
hdl/mos_pkg.sv
hdl/mos_div.sv
hdl/mos_datapath.sv
hdl/mos_ctrl.sv
hdl/milne_ode_solver_unit.sv
hdl/mos_checker.sv
tb/testbench.sv
